/* rtl/sequential_list_insert_remove_macros.svh */
// ----------------------------------------------------------------------------
// Sequential list insert/remove - assertion macros
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SEQUENTIAL_LIST_INSERT_REMOVE_MACROS_SVH
`define SEQUENTIAL_LIST_INSERT_REMOVE_MACROS_SVH

// same-cycle implication, disabled in reset
`define SLIR_CHECK_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SLIR_CHECK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/slir_pkg.sv */
// ----------------------------------------------------------------------------
// Sequential list insert/remove - package
// Opcodes, status codes, operation kinds and controller/datapath links.
// ----------------------------------------------------------------------------
package slir_pkg;

    localparam logic [2:0] OP_INS_HEAD = 3'd0;
    localparam logic [2:0] OP_INS_POS  = 3'd1;
    localparam logic [2:0] OP_INS_TAIL = 3'd2;
    localparam logic [2:0] OP_REM_HEAD = 3'd3;
    localparam logic [2:0] OP_REM_POS  = 3'd4;
    localparam logic [2:0] OP_REM_TAIL = 3'd5;
    localparam logic [2:0] OP_READ     = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_INSERT = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic place;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic work;
        logic is_insert;
        logic seq_idle;
        logic out_free;
    } stat_t;

endpackage

/* rtl/slir_ram.sv */
// ----------------------------------------------------------------------------
// Sequential list insert/remove - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/slir_datapath.sv */
// ----------------------------------------------------------------------------
// Sequential list insert/remove - datapath
// Entry count, operation decode, slot store, shift sequencer and result register.
// ----------------------------------------------------------------------------
module slir_datapath #(
    parameter int LIST_DEPTH  = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  slir_pkg::cmd_t      cmd,
    output slir_pkg::stat_t     stat,
    input  logic [2:0]          opcode,
    input  logic [8:0]          position,
    input  logic [31:0]         item_value,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output logic [31:0]         out_value,
    output logic [9:0]          element_total,
    output logic [1:0]          status
);

    localparam int AW   = $clog2(LIST_DEPTH);
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    localparam int CMPW = (CW > 9) ? CW : 9;
    localparam logic [CW-1:0] FULL_CNT = CW'(LIST_DEPTH);

    logic [CW-1:0]          cnt_reg,   cnt_next;
    logic [1:0]             kind_reg,  kind_next;
    logic [1:0]             st_reg,    st_next;
    logic [CW-1:0]          ep_reg,    ep_next;
    logic [VALUE_WIDTH-1:0] val_reg,   val_next;
    logic [CW-1:0]          rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]          rem_reg,   rem_next;
    logic                   pend_reg,  pend_next;
    logic                   first_reg, first_next;
    logic [CW-1:0]          prev_reg,  prev_next;
    logic [VALUE_WIDTH-1:0] res_reg,   res_next;
    logic                   ov_reg,    ov_next;
    logic [31:0]            oval_reg,  oval_next;
    logic [9:0]             otot_reg,  otot_next;
    logic [1:0]             ost_reg,   ost_next;

    logic [CMPW-1:0]        cnt_w;
    logic [CMPW-1:0]        ep_w;
    logic [1:0]             kind_in;
    logic [1:0]             st_in;
    logic                   rd_issue;
    logic                   we;
    logic [CW-1:0]          waddr_full;
    logic [VALUE_WIDTH-1:0] wdata;
    logic [VALUE_WIDTH-1:0] rdata;
    logic                   out_free;
    logic                   ok_reg;

    assign cnt_w = CMPW'(cnt_reg);

    always_comb
    begin
        kind_in = slir_pkg::KIND_NONE;
        ep_w    = '0;
        case (opcode)
            slir_pkg::OP_INS_HEAD:
            begin
                kind_in = slir_pkg::KIND_INSERT;
                ep_w    = '0;
            end
            slir_pkg::OP_INS_POS:
            begin
                kind_in = slir_pkg::KIND_INSERT;
                ep_w    = CMPW'(position);
            end
            slir_pkg::OP_INS_TAIL:
            begin
                kind_in = slir_pkg::KIND_INSERT;
                ep_w    = cnt_w;
            end
            slir_pkg::OP_REM_HEAD:
            begin
                kind_in = slir_pkg::KIND_REMOVE;
                ep_w    = '0;
            end
            slir_pkg::OP_REM_POS:
            begin
                kind_in = slir_pkg::KIND_REMOVE;
                ep_w    = CMPW'(position);
            end
            slir_pkg::OP_REM_TAIL:
            begin
                kind_in = slir_pkg::KIND_REMOVE;
                ep_w    = cnt_w - CMPW'(1);
            end
            slir_pkg::OP_READ:
            begin
                kind_in = slir_pkg::KIND_READ;
                ep_w    = CMPW'(position);
            end
            default:
            begin
                kind_in = slir_pkg::KIND_NONE;
                ep_w    = '0;
            end
        endcase
    end

    always_comb
    begin
        st_in = slir_pkg::ST_OK;
        case (kind_in)
            slir_pkg::KIND_INSERT:
            begin
                if (cnt_reg == FULL_CNT)
                begin
                    st_in = slir_pkg::ST_FULL;
                end
                else if (ep_w > cnt_w)
                begin
                    st_in = slir_pkg::ST_RANGE;
                end
            end
            slir_pkg::KIND_REMOVE, slir_pkg::KIND_READ:
            begin
                if (cnt_reg == '0)
                begin
                    st_in = slir_pkg::ST_EMPTY;
                end
                else if (ep_w >= cnt_w)
                begin
                    st_in = slir_pkg::ST_RANGE;
                end
            end
            default:
            begin
                st_in = slir_pkg::ST_OK;
            end
        endcase
    end

    assign ok_reg   = (st_reg == slir_pkg::ST_OK);
    assign out_free = !ov_reg || !rsp_stall;
    assign rd_issue = cmd.step && (rem_reg != '0);

    always_comb
    begin
        cnt_next    = cnt_reg;
        kind_next   = kind_reg;
        st_next     = st_reg;
        ep_next     = ep_reg;
        val_next    = val_reg;
        rd_ptr_next = rd_ptr_reg;
        rem_next    = rem_reg;
        pend_next   = pend_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        res_next    = res_reg;
        ov_next     = ov_reg && rsp_stall;
        oval_next   = oval_reg;
        otot_next   = otot_reg;
        ost_next    = ost_reg;
        we          = 1'b0;
        waddr_full  = ep_reg;
        wdata       = val_reg;

        if (cmd.load)
        begin
            kind_next  = kind_in;
            st_next    = st_in;
            ep_next    = CW'(ep_w);
            val_next   = VALUE_WIDTH'(item_value);
            pend_next  = 1'b0;
            res_next   = '0;
            first_next = (kind_in == slir_pkg::KIND_REMOVE) || (kind_in == slir_pkg::KIND_READ);
            case (kind_in)
                slir_pkg::KIND_INSERT:
                begin
                    rem_next    = cnt_reg - CW'(ep_w);
                    rd_ptr_next = cnt_reg - CW'(1);
                end
                slir_pkg::KIND_REMOVE:
                begin
                    rem_next    = cnt_reg - CW'(ep_w);
                    rd_ptr_next = CW'(ep_w);
                end
                slir_pkg::KIND_READ:
                begin
                    rem_next    = CW'(1);
                    rd_ptr_next = CW'(ep_w);
                end
                default:
                begin
                    rem_next    = '0;
                    rd_ptr_next = '0;
                end
            endcase
        end

        if (cmd.step)
        begin
            pend_next = rd_issue;
            if (rd_issue)
            begin
                rem_next  = rem_reg - CW'(1);
                prev_next = rd_ptr_reg;
                if (kind_reg == slir_pkg::KIND_INSERT)
                begin
                    rd_ptr_next = rd_ptr_reg - CW'(1);
                end
                else
                begin
                    rd_ptr_next = rd_ptr_reg + CW'(1);
                end
            end
            if (pend_reg)
            begin
                if (first_reg)
                begin
                    res_next   = rdata;
                    first_next = 1'b0;
                end
                else
                begin
                    we    = 1'b1;
                    wdata = rdata;
                    if (kind_reg == slir_pkg::KIND_INSERT)
                    begin
                        waddr_full = prev_reg + CW'(1);
                    end
                    else
                    begin
                        waddr_full = prev_reg - CW'(1);
                    end
                end
            end
        end

        if (cmd.place)
        begin
            we         = 1'b1;
            waddr_full = ep_reg;
            wdata      = val_reg;
        end

        if (cmd.finish)
        begin
            if (ok_reg && (kind_reg == slir_pkg::KIND_INSERT))
            begin
                cnt_next = cnt_reg + CW'(1);
            end
            else if (ok_reg && (kind_reg == slir_pkg::KIND_REMOVE))
            begin
                cnt_next = cnt_reg - CW'(1);
            end
            ov_next   = 1'b1;
            ost_next  = st_reg;
            otot_next = 10'(cnt_next);
            if (ok_reg && ((kind_reg == slir_pkg::KIND_REMOVE) ||
                           (kind_reg == slir_pkg::KIND_READ)))
            begin
                oval_next = 32'(res_reg);
            end
            else
            begin
                oval_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            kind_reg  <= slir_pkg::KIND_NONE;
            st_reg    <= slir_pkg::ST_OK;
            rem_reg   <= '0;
            pend_reg  <= 1'b0;
            first_reg <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
            st_reg    <= st_next;
            rem_reg   <= rem_next;
            pend_reg  <= pend_next;
            first_reg <= first_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ep_reg     <= ep_next;
        val_reg    <= val_next;
        rd_ptr_reg <= rd_ptr_next;
        prev_reg   <= prev_next;
        res_reg    <= res_next;
        oval_reg   <= oval_next;
        otot_reg   <= otot_next;
        ost_reg    <= ost_next;
    end

    slir_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (LIST_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr_full[AW-1:0]),
        .wdata (wdata),
        .re    (rd_issue),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (rdata)
    );

    assign stat.work      = ok_reg && (kind_reg != slir_pkg::KIND_NONE);
    assign stat.is_insert = (kind_reg == slir_pkg::KIND_INSERT);
    assign stat.seq_idle  = (rem_reg == '0) && !pend_reg;
    assign stat.out_free  = out_free;

    assign rsp_valid     = ov_reg;
    assign out_value     = oval_reg;
    assign element_total = otot_reg;
    assign status        = ost_reg;

endmodule

/* rtl/slir_ctrl.sv */
// ----------------------------------------------------------------------------
// Sequential list insert/remove - controller
// Sequences accept, check, shift, place and result load for one transaction.
// ----------------------------------------------------------------------------
module slir_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  slir_pkg::stat_t stat,
    output slir_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MOVE  = 3'd2;
    localparam logic [2:0] S_PLACE = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.work ? S_MOVE : S_DONE;
            end
            S_MOVE:
            begin
                cmd.step = 1'b1;
                if (stat.seq_idle)
                begin
                    state_next = stat.is_insert ? S_PLACE : S_DONE;
                end
            end
            S_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/sequential_list_insert_remove.sv */
// Sequence: rejected items and opcode seven go from the check straight to the result;
// an insert shifts the entries from position p up, places the item, then loads the result;
// a remove or read shifts or fetches from position p, then loads the result.
// Throughput: one transaction at a time; shifting moves one slot per cycle through the
// single write port of the slot store, so the entry shift loop sets the rate.
// Reset: asynchronous, clears the entry count and handshake state; store not cleared.
// ----------------------------------------------------------------------------
// Sequential list insert/remove - top level
// Bounded ordered list with insert and remove at head, tail or position, and read at position.
// ----------------------------------------------------------------------------
module sequential_list_insert_remove #(
    parameter int LIST_DEPTH  = 512,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [2:0]  opcode,
    input  logic [8:0]  position,
    input  logic [31:0] item_value,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [31:0] out_value,
    output logic [9:0]  element_total,
    output logic [1:0]  status
);

    slir_pkg::cmd_t  cmd;
    slir_pkg::stat_t stat;

    slir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    slir_datapath #(
        .LIST_DEPTH  (LIST_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .opcode        (opcode),
        .position      (position),
        .item_value    (item_value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_value     (out_value),
        .element_total (element_total),
        .status        (status)
    );

endmodule

/* rtl/slir_checker.sv */
// ----------------------------------------------------------------------------
// Sequential list insert/remove - port checker
// Result consistency and output hold checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "sequential_list_insert_remove_macros.svh"

module slir_checker #(
    parameter int LIST_DEPTH = 512
) (
    input logic        clk,
    input logic        rst_n,
    input logic        rsp_valid,
    input logic        rsp_stall,
    input logic [31:0] out_value,
    input logic [9:0]  element_total,
    input logic [1:0]  status
);

    localparam logic [9:0] FULL_TOTAL = 10'(LIST_DEPTH);

    `SLIR_CHECK_NOW(a_reject_zero, clk, rst_n, rsp_valid && (status != slir_pkg::ST_OK), out_value == 32'd0, "rejected transaction carries a value")
    `SLIR_CHECK_NOW(a_empty_total, clk, rst_n, rsp_valid && (status == slir_pkg::ST_EMPTY), element_total == 10'd0, "empty status with nonzero count")
    `SLIR_CHECK_NOW(a_full_total, clk, rst_n, rsp_valid && (status == slir_pkg::ST_FULL), element_total == FULL_TOTAL, "full status without full count")
    `SLIR_CHECK_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && rsp_stall, rsp_valid && $stable(out_value) && $stable(element_total) && $stable(status), "stalled result changed")

endmodule

bind sequential_list_insert_remove slir_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_slir_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .out_value     (out_value),
    .element_total (element_total),
    .status        (status)
);

/* sim/tb_sequential_list_insert_remove.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sequential list insert/remove - testbench
// Drives insert, remove and read transactions through the request channel and
// checks every response against a queue-based copy of the list. The run walks
// the list from empty to full and back, with random idle bursts on both sides
// and one long response hold-off that backs up the request channel.
// ----------------------------------------------------------------------------
module tb_sequential_list_insert_remove;

    localparam int         DEPTH        = 512;
    localparam logic [2:0] OP_NOP       = 3'd7;
    localparam int         RANDOM_ITEMS = 1900;
    localparam int         QUIET_TAIL   = 200;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         WATCHDOG_MAX = 5000;
    localparam int         DRAIN_CYCLES = 50;

    typedef struct packed {
        logic [31:0] value;
        logic [9:0]  total;
        logic [1:0]  status;
    } list_result_t;

    typedef enum logic [1:0] {MIX_OPS, FILL_OPS, DRAIN_OPS} traffic_mode_t;

    class slot_list_model;
        logic [31:0]  entries[$];
        list_result_t expected_results[$];
        int           error_count = 0;

        function void apply_op(logic [2:0] op, logic [8:0] pos, logic [31:0] val);
            list_result_t r;
            int           cnt;
            int           idx;
            cnt      = entries.size();
            r.value  = '0;
            r.status = slir_pkg::ST_OK;
            case (op)
                slir_pkg::OP_INS_HEAD, slir_pkg::OP_INS_POS, slir_pkg::OP_INS_TAIL:
                begin
                    idx = (op == slir_pkg::OP_INS_HEAD) ? 0 :
                          (op == slir_pkg::OP_INS_POS) ? int'(pos) : cnt;
                    if (cnt >= DEPTH)
                        r.status = slir_pkg::ST_FULL;
                    else if (idx > cnt)
                        r.status = slir_pkg::ST_RANGE;
                    else
                        entries.insert(idx, val);
                end
                slir_pkg::OP_REM_HEAD, slir_pkg::OP_REM_POS, slir_pkg::OP_REM_TAIL,
                slir_pkg::OP_READ:
                begin
                    if (op == slir_pkg::OP_REM_HEAD)
                        idx = 0;
                    else if (op == slir_pkg::OP_REM_TAIL)
                        idx = (cnt == 0) ? 0 : cnt - 1;
                    else
                        idx = int'(pos);
                    if (cnt == 0)
                        r.status = slir_pkg::ST_EMPTY;
                    else if (idx >= cnt)
                        r.status = slir_pkg::ST_RANGE;
                    else
                    begin
                        r.value = entries[idx];
                        if (op != slir_pkg::OP_READ)
                            entries.delete(idx);
                    end
                end
                default:
                    ;
            endcase
            r.total = 10'(entries.size());
            expected_results.push_back(r);
        endfunction

        function void compare_result(logic [31:0] value, logic [9:0] total,
                                     logic [1:0] status);
            list_result_t e;
            if (expected_results.size() == 0)
            begin
                $error("unexpected transaction: out_value %h element_total %0d status %0d",
                       value, total, status);
                error_count++;
                return;
            end
            e = expected_results.pop_front();
            if (value !== e.value)
            begin
                $error("out_value: expected %h, got %h", e.value, value);
                error_count++;
            end
            if (total !== e.total)
            begin
                $error("element_total: expected %0d, got %0d", e.total, total);
                error_count++;
            end
            if (status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                error_count++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [2:0]  opcode;
    logic [8:0]  position;
    logic [31:0] item_value;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [31:0] out_value;
    logic [9:0]  element_total;
    logic [1:0]  status;

    slot_list_model list_model;
    bit             idle_on;
    bit             hold_rsp;
    int             quiet_cycles;
    int             random_sent;

    sequential_list_insert_remove #(
        .LIST_DEPTH  (DEPTH),
        .VALUE_WIDTH (32)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .opcode        (opcode),
        .position      (position),
        .item_value    (item_value),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .out_value     (out_value),
        .element_total (element_total),
        .status        (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                list_model.apply_op(opcode, position, item_value);
            if (rsp_valid && !rsp_stall)
                list_model.compare_result(out_value, element_total, status);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX)
            begin
                $display("tb_sequential_list_insert_remove: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_rsp)
            begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
                rsp_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                rsp_stall <= 1'b0;
            end
            else
                rsp_stall <= 1'b0;
        end
    end

    task automatic send_op(logic [2:0] op, logic [8:0] pos, logic [31:0] val);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
        end
        req_valid  <= 1'b1;
        opcode     <= op;
        position   <= pos;
        item_value <= val;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [8:0] pick_position(int cnt);
        int roll;
        int p;
        roll = $urandom_range(0, 99);
        if (roll < 8)
            p = $urandom_range(0, DEPTH - 1);
        else if (roll < 50)
            p = cnt - int'($urandom_range(0, (cnt < 8) ? cnt : 8));
        else
            p = $urandom_range(0, cnt);
        if (p > DEPTH - 1)
            p = DEPTH - 1;
        return 9'(p);
    endfunction

    function automatic logic [31:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 32'h0000_0000;
        if (roll < 10)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    task automatic send_random(traffic_mode_t mode);
        int         roll;
        logic [2:0] op;
        roll = $urandom_range(0, 99);
        case (mode)
            FILL_OPS:
                op = (roll < 85) ? slir_pkg::OP_INS_TAIL : (roll < 92) ? slir_pkg::OP_READ :
                     (roll < 96) ? slir_pkg::OP_INS_POS : slir_pkg::OP_REM_TAIL;
            DRAIN_OPS:
                op = (roll < 85) ? slir_pkg::OP_REM_TAIL : (roll < 92) ? slir_pkg::OP_READ :
                     (roll < 96) ? slir_pkg::OP_REM_POS : slir_pkg::OP_INS_TAIL;
            default:
                op = (roll < 3) ? OP_NOP : 3'($urandom_range(0, 6));
        endcase
        send_op(op, pick_position(list_model.entries.size()), pick_value());
        random_sent++;
        if (RANDOM_ITEMS - random_sent < QUIET_TAIL)
            idle_on = 1'b0;
    endtask

    task automatic run_directed();
        send_op(slir_pkg::OP_REM_HEAD, 9'd0,   32'h0);
        send_op(slir_pkg::OP_REM_TAIL, 9'd0,   32'h0);
        send_op(slir_pkg::OP_REM_POS,  9'd0,   32'h0);
        send_op(slir_pkg::OP_READ,     9'd0,   32'h0);
        send_op(OP_NOP,                9'd0,   32'hFFFF_FFFF);
        send_op(slir_pkg::OP_INS_POS,  9'd1,   32'hDEAD_BEEF);
        send_op(slir_pkg::OP_INS_POS,  9'd0,   32'h0000_0000);
        send_op(slir_pkg::OP_INS_HEAD, 9'd511, 32'hFFFF_FFFF);
        send_op(slir_pkg::OP_INS_TAIL, 9'd0,   32'h1234_5678);
        send_op(slir_pkg::OP_INS_POS,  9'd3,   32'hA5A5_5A5A);
        send_op(slir_pkg::OP_INS_POS,  9'd5,   32'h5A5A_A5A5);
        send_op(slir_pkg::OP_INS_POS,  9'd511, 32'h0F0F_F0F0);
        send_op(slir_pkg::OP_READ,     9'd0,   32'h0);
        send_op(slir_pkg::OP_READ,     9'd1,   32'h0);
        send_op(slir_pkg::OP_READ,     9'd3,   32'h0);
        send_op(slir_pkg::OP_READ,     9'd4,   32'h0);
        send_op(slir_pkg::OP_READ,     9'd511, 32'h0);
        send_op(slir_pkg::OP_REM_POS,  9'd4,   32'h0);
        send_op(slir_pkg::OP_REM_POS,  9'd1,   32'h0);
        send_op(OP_NOP,                9'd2,   32'h0);
        send_op(slir_pkg::OP_REM_HEAD, 9'd0,   32'h0);
        send_op(slir_pkg::OP_REM_TAIL, 9'd0,   32'h0);
        send_op(slir_pkg::OP_REM_TAIL, 9'd0,   32'h0);
    endtask

    initial
    begin
        int guard;
        list_model   = new();
        idle_on      = 1'b0;
        hold_rsp     = 1'b0;
        quiet_cycles = 0;
        random_sent  = 0;
        rst_n        = 1'b0;
        req_valid    = 1'b0;
        opcode       = slir_pkg::OP_INS_HEAD;
        position     = '0;
        item_value   = '0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        run_directed();

        idle_on = 1'b1;
        repeat (100) send_random(MIX_OPS);
        hold_rsp = 1'b1;
        repeat (200) send_random(MIX_OPS);

        guard = 0;
        while (list_model.entries.size() < DEPTH && guard < 1500)
        begin
            send_random(FILL_OPS);
            guard++;
        end
        repeat (40) send_random(FILL_OPS);
        repeat (200) send_random(MIX_OPS);

        guard = 0;
        while (list_model.entries.size() > 0 && guard < 1500)
        begin
            send_random(DRAIN_OPS);
            guard++;
        end
        repeat (30) send_random(DRAIN_OPS);

        guard = 0;
        while ((random_sent < RANDOM_ITEMS || guard < 150) && guard < 2000)
        begin
            send_random(MIX_OPS);
            guard++;
        end

        idle_on = 1'b0;
        req_valid <= 1'b0;
        while (list_model.expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (list_model.error_count == 0)
            $display("tb_sequential_list_insert_remove: PASS");
        else
            $display("tb_sequential_list_insert_remove: FAIL");
        $finish;
    end

endmodule
